FILE: design/csl_pkg.sv
package csl_pkg;

    // Token kinds as they appear on the result channel.
    localparam logic [2:0] KIND_IDENT    = 3'd0;
    localparam logic [2:0] KIND_PUNCT    = 3'd1;
    localparam logic [2:0] KIND_KEYWORD  = 3'd2;
    localparam logic [2:0] KIND_STRING   = 3'd3;
    localparam logic [2:0] KIND_NUMBER   = 3'd4;
    localparam logic [2:0] KIND_END      = 3'd5;
    localparam logic [2:0] KIND_UNCLOSED = 3'd6;
    localparam logic [2:0] KIND_INVALID  = 3'd7;

    // Depth of the token queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Longest keyword and the keyword spellings, first byte in the low bits.
    localparam logic [15:0] KW_MAX_LEN = 16'd6;
    localparam logic [47:0] KW_RETURN  = 48'h6E72_7574_6572;
    localparam logic [47:0] KW_IF      = 48'h0000_0000_6669;
    localparam logic [47:0] KW_ELSE    = 48'h0000_6573_6C65;
    localparam logic [47:0] KW_FOR     = 48'h0000_0072_6F66;
    localparam logic [47:0] KW_WHILE   = 48'h0065_6C69_6877;
    localparam logic [47:0] KW_INT     = 48'h0000_0074_6E69;
    localparam logic [47:0] KW_SIZEOF  = 48'h666F_657A_6973;
    localparam logic [47:0] KW_CHAR    = 48'h0000_7261_6863;

    // One token as it leaves the front part.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } tok_t;

    // All tokens caused by one input byte. Only the first may carry a number
    // value or an identifier prefix, which share the aux field.
    typedef struct packed {
        logic        two;
        tok_t        tok0;
        tok_t        tok1;
        logic [63:0] aux;
    } pair_t;

    // The prefix holds the identifier's first six bytes, zero padded, so a
    // match on all six bytes also settles the length for short identifiers.
    function automatic logic kw_match(input logic [47:0] prefix);
        kw_match = (prefix == KW_RETURN) || (prefix == KW_IF) ||
                   (prefix == KW_ELSE) || (prefix == KW_FOR) ||
                   (prefix == KW_WHILE) || (prefix == KW_INT) ||
                   (prefix == KW_SIZEOF) || (prefix == KW_CHAR);
    endfunction

endpackage

FILE: design/c_subset_lexer_top.sv
// A byte accepted on the input is written into the token queue and then loaded
// into the output stage registers before its first token shows on the result port.
// Input rate: one byte per cycle while the queue is not full; a byte that yields
// two tokens gives one result beat per token, and a four-entry queue absorbs that.
// Reset: synchronous, active low; it empties the queue and the output stage and
// returns the lexer to idle at position zero.
module c_subset_lexer_top #(
    parameter longint unsigned TEXT_BYTES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_token_kind,
    output logic [15:0] m_token_start,
    output logic [15:0] m_token_length,
    output logic [63:0] m_number_value,
    output logic        m_last_of_run
);
    import csl_pkg::*;

    logic  push_valid;
    pair_t push_data;
    logic  q_full;
    logic  head_valid;
    pair_t head_data;
    logic  pop;

    csl_front #(
        .TEXT_BYTES(TEXT_BYTES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .push_valid    (push_valid),
        .push_data     (push_data),
        .q_full        (q_full)
    );

    csl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    csl_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_data      (head_data),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_number_value (m_number_value),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

FILE: design/csl_queue.sv
module csl_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    input  csl_pkg::pair_t push_data,
    output logic           full,
    output logic           head_valid,
    output csl_pkg::pair_t head_data,
    input  logic           pop
);
    import csl_pkg::*;

    pair_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/csl_front.sv
module csl_front #(
    parameter longint unsigned TEXT_BYTES = 65536
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_text_byte,
    input  logic           s_end_of_text,
    output logic           push_valid,
    output csl_pkg::pair_t push_data,
    input  logic           q_full
);
    import csl_pkg::*;

    localparam int POS_W = $clog2(TEXT_BYTES);
    localparam int EXT_W = (POS_W > 16) ? POS_W : 16;

    // Lexer modes.
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_IDENT    = 3'd1;
    localparam logic [2:0] MODE_NUMBER   = 3'd2;
    localparam logic [2:0] MODE_STRING   = 3'd3;
    localparam logic [2:0] MODE_OPERATOR = 3'd4;
    localparam logic [2:0] MODE_ERROR    = 3'd5;

    logic [2:0]       mode_reg, mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      pstart_reg, pstart_next;
    logic [15:0]      plen_reg, plen_next;
    logic [63:0]      acc_reg, acc_next;
    logic [47:0]      prefix_reg, prefix_next;

    logic             accept;
    logic             at_end;
    logic [EXT_W-1:0] pos_ext;
    logic [15:0]      pos16;
    logic [15:0]      plen_inc;
    logic             is_space, is_digit, is_letter, is_punct, is_op;
    logic [67:0]      acc_mul;
    logic [63:0]      acc_sat;
    logic             flush_v;
    tok_t             flush_tok;
    logic [63:0]      flush_aux;
    logic             a_v, b_v;
    tok_t             a_tok, b_tok;
    logic [63:0]      a_aux;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign at_end  = s_end_of_text || (s_text_byte == 8'd0);
    assign pos_ext = EXT_W'(pos_reg);
    assign pos16   = pos_ext[15:0];
    assign plen_inc = (plen_reg == 16'hFFFF) ? plen_reg : plen_reg + 16'd1;

    // Byte classes.
    assign is_space  = (s_text_byte == 8'd32) ||
                       (s_text_byte >= 8'd9 && s_text_byte <= 8'd13);
    assign is_digit  = (s_text_byte >= 8'd48 && s_text_byte <= 8'd57);
    assign is_letter = (s_text_byte >= 8'd97 && s_text_byte <= 8'd122) ||
                       (s_text_byte >= 8'd65 && s_text_byte <= 8'd90) ||
                       (s_text_byte == 8'd95);
    assign is_punct  = (s_text_byte >= 8'd33 && s_text_byte <= 8'd47) ||
                       (s_text_byte >= 8'd58 && s_text_byte <= 8'd64) ||
                       (s_text_byte >= 8'd91 && s_text_byte <= 8'd96) ||
                       (s_text_byte >= 8'd123 && s_text_byte <= 8'd126);
    assign is_op     = (s_text_byte == 8'd61) || (s_text_byte == 8'd33) ||
                       (s_text_byte == 8'd60) || (s_text_byte == 8'd62);

    // Decimal step: acc * 10 + digit, saturating when it leaves 64 bits.
    assign acc_mul = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) +
                     68'(s_text_byte - 8'd48);
    assign acc_sat = (acc_mul[67:64] != 4'd0) ? {64{1'b1}} : acc_mul[63:0];

    // Token that a pending identifier, number or operator turns into.
    always_comb begin
        flush_v   = (mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER) ||
                    (mode_reg == MODE_OPERATOR);
        flush_tok = '{kind: KIND_IDENT, start: pstart_reg, length: plen_reg};
        flush_aux = {16'd0, prefix_reg};
        if (mode_reg == MODE_NUMBER) begin
            flush_tok.kind = KIND_NUMBER;
            flush_aux      = acc_reg;
        end else if (mode_reg == MODE_OPERATOR) begin
            flush_tok.kind   = KIND_PUNCT;
            flush_tok.length = 16'd1;
            flush_aux        = '0;
        end
    end

    // Per-byte lexer step. Token a comes before token b.
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        acc_next    = acc_reg;
        prefix_next = prefix_reg;
        a_v         = 1'b0;
        a_tok       = flush_tok;
        a_aux       = '0;
        b_v         = 1'b0;
        b_tok       = '{kind: KIND_END, start: pos16, length: 16'd0};

        if (accept) begin
            if (at_end) begin
                // Flush what is pending, then the end token; back to reset state.
                if (mode_reg == MODE_STRING) begin
                    a_v   = 1'b1;
                    a_tok = '{kind: KIND_UNCLOSED, start: pstart_reg, length: plen_reg};
                end else begin
                    a_v   = flush_v;
                    a_aux = flush_aux;
                end
                b_v         = 1'b1;
                mode_next   = MODE_IDLE;
                pos_next    = '0;
                pstart_next = '0;
                plen_next   = '0;
                acc_next    = '0;
                prefix_next = '0;
            end else begin
                pos_next = (pos_reg == POS_W'(TEXT_BYTES - 1)) ? '0 : pos_reg + 1'b1;
                case (mode_reg)
                    MODE_ERROR: begin
                    end
                    MODE_STRING: begin
                        if (s_text_byte == 8'd34) begin
                            a_v       = 1'b1;
                            a_tok     = '{kind: KIND_STRING, start: pstart_reg,
                                          length: plen_inc};
                            mode_next = MODE_IDLE;
                        end else if (s_text_byte == 8'd10) begin
                            a_v       = 1'b1;
                            a_tok     = '{kind: KIND_UNCLOSED, start: pstart_reg,
                                          length: plen_reg};
                            mode_next = MODE_ERROR;
                        end else begin
                            plen_next = plen_inc;
                        end
                    end
                    default: begin
                        if (mode_reg == MODE_OPERATOR && s_text_byte == 8'd61) begin
                            // Two-byte comparison operator.
                            a_v       = 1'b1;
                            a_tok     = '{kind: KIND_PUNCT, start: pstart_reg,
                                          length: 16'd2};
                            mode_next = MODE_IDLE;
                        end else if (mode_reg == MODE_IDENT && (is_letter || is_digit)) begin
                            for (int i = 0; i < 6; i++) begin
                                if (plen_reg == 16'(i)) begin
                                    prefix_next[8*i +: 8] = s_text_byte;
                                end
                            end
                            plen_next = plen_inc;
                        end else if (mode_reg == MODE_NUMBER && is_digit) begin
                            acc_next  = acc_sat;
                            plen_next = plen_inc;
                        end else begin
                            // Close any pending token; a byte that is not white space starts a new one here.
                            a_v         = flush_v;
                            a_aux       = flush_aux;
                            mode_next   = MODE_IDLE;
                            pstart_next = pos16;
                            plen_next   = 16'd1;
                            b_tok.start  = pos16;
                            b_tok.length = 16'd1;
                            if (is_space) begin
                            end else if (is_digit) begin
                                mode_next = MODE_NUMBER;
                                acc_next  = 64'(s_text_byte - 8'd48);
                            end else if (s_text_byte == 8'd34) begin
                                mode_next = MODE_STRING;
                            end else if (is_letter) begin
                                mode_next   = MODE_IDENT;
                                prefix_next = {40'd0, s_text_byte};
                            end else if (is_op) begin
                                mode_next = MODE_OPERATOR;
                            end else if (is_punct) begin
                                b_v        = 1'b1;
                                b_tok.kind = KIND_PUNCT;
                            end else begin
                                b_v        = 1'b1;
                                b_tok.kind = KIND_INVALID;
                                mode_next  = MODE_ERROR;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Pack the tokens of this byte, first token first.
    always_comb begin
        push_valid     = accept && (a_v || b_v);
        push_data.two  = a_v && b_v;
        push_data.tok0 = a_v ? a_tok : b_tok;
        push_data.tok1 = b_tok;
        push_data.aux  = a_v ? a_aux : 64'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            acc_reg    <= '0;
            prefix_reg <= '0;
        end else begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            acc_reg    <= acc_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

FILE: design/csl_back.sv
module csl_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  csl_pkg::pair_t head_data,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [2:0]     m_token_kind,
    output logic [15:0]    m_token_start,
    output logic [15:0]    m_token_length,
    output logic [63:0]    m_number_value,
    output logic           m_last_of_run
);
    import csl_pkg::*;

    logic        valid_reg, valid_next;
    logic        sel_reg, sel_next;
    logic        two_reg;
    tok_t        tok0_reg, tok1_reg;
    logic [63:0] value_reg;
    tok_t        head_tok0;
    logic [63:0] head_value;
    logic        out_fire;
    logic        last_tok;
    logic        load;

    // Resolve keywords and the number value as the entry leaves the queue.
    always_comb begin
        head_tok0  = head_data.tok0;
        head_value = (head_data.tok0.kind == KIND_NUMBER) ? head_data.aux : 64'd0;
        if (head_data.tok0.kind == KIND_IDENT && head_data.tok0.length <= KW_MAX_LEN &&
            kw_match(head_data.aux[47:0])) begin
            head_tok0.kind = KIND_KEYWORD;
        end
    end

    assign out_fire = valid_reg && m_ready;
    assign last_tok = sel_reg || !two_reg;
    assign load     = !valid_reg || (out_fire && last_tok);
    assign pop      = load && head_valid;

    // Beat sequencing: one or two beats per entry.
    always_comb begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (load) begin
            valid_next = head_valid;
            sel_next   = 1'b0;
        end else if (out_fire) begin
            sel_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    // Entry payload held for the output beats.
    always_ff @(posedge aclk) begin
        if (pop) begin
            two_reg   <= head_data.two;
            tok0_reg  <= head_tok0;
            tok1_reg  <= head_data.tok1;
            value_reg <= head_value;
        end
    end

    assign m_valid        = valid_reg;
    assign m_token_kind   = sel_reg ? tok1_reg.kind : tok0_reg.kind;
    assign m_token_start  = sel_reg ? tok1_reg.start : tok0_reg.start;
    assign m_token_length = sel_reg ? tok1_reg.length : tok0_reg.length;
    assign m_number_value = sel_reg ? 64'd0 : value_reg;
    assign m_last_of_run  = last_tok;

endmodule

FILE: design/csl_checker.sv
module csl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_token_kind,
    input logic [15:0] m_token_length,
    input logic [63:0] m_number_value,
    input logic        m_last_of_run
);
    import csl_pkg::*;

    // A stalled result beat keeps its kind and length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind) &&
        $stable(m_token_length))
        else $error("result beat changed while stalled");

    // The end token is empty and always closes its run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == KIND_END |-> m_token_length == 16'd0 && m_last_of_run)
        else $error("malformed end token");

    // Only number tokens carry a value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != KIND_NUMBER |-> m_number_value == 64'd0)
        else $error("value on a non-number token");

    // Keywords are two to six bytes long.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == KIND_KEYWORD |->
        m_token_length >= 16'd2 && m_token_length <= KW_MAX_LEN)
        else $error("keyword with impossible length");

endmodule

bind c_subset_lexer_top csl_checker u_csl_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_token_kind   (m_token_kind),
    .m_token_length (m_token_length),
    .m_number_value (m_number_value),
    .m_last_of_run  (m_last_of_run)
);
